### rtl/pmrt_pkg.sv
package pmrt_pkg;

    // Default number of regions the table holds.
    localparam int TABLE_ENTRIES_DFLT = 16;

    // Reset value of the memory size register.
    localparam logic [30:0] MEM_SIZE_RST = 31'd65536;

    // Request commands.
    localparam logic [1:0] CMD_ALLOCATE   = 2'd0;
    localparam logic [1:0] CMD_ACCESS     = 2'd1;
    localparam logic [1:0] CMD_FREE_OWNER = 2'd2;
    localparam logic [1:0] CMD_FREE_ALL   = 2'd3;

    // Response status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BOUNDS   = 2'd1;
    localparam logic [1:0] ST_CONFLICT = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         owner_id;
        logic signed [31:0] range_base;
        logic [30:0]        range_size;
    } t_req;

    typedef struct packed {
        logic       granted;
        logic [1:0] status;
    } t_rsp;

    // One stored region. The last address is kept instead of the size.
    typedef struct packed {
        logic [7:0]         owner;
        logic signed [31:0] base;
        logic signed [31:0] last;
    } t_entry;

    typedef struct packed {
        logic contain;
        logic overlap;
    } t_cmp_res;

endpackage

### rtl/pmrt_ram.sv
module pmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pmrt_cmp.sv
module pmrt_cmp
    import pmrt_pkg::*;
(
    input  logic signed [32:0] i_first,
    input  logic signed [33:0] i_last,
    input  t_entry             i_entry,
    output t_cmp_res           o_res
);

    logic signed [33:0] first_x;
    logic signed [33:0] lo;
    logic signed [33:0] hi;

    assign first_x = $signed({i_first[32], i_first});
    assign lo      = $signed({{2{i_entry.base[31]}}, i_entry.base});
    assign hi      = $signed({{2{i_entry.last[31]}}, i_entry.last});

    // A range is contained when it starts at or after the stored base and
    // ends at or before the stored last address. It overlaps unless it lies
    // wholly before or wholly after the stored region.
    assign o_res.contain = (first_x >= lo) && (i_last <= hi);
    assign o_res.overlap = !((i_last < lo) || (first_x > hi));

endmodule

### rtl/process_memory_region_table.sv
// Memory region protection table. The block holds up to TABLE_ENTRIES regions,
// each an owner id with a base and a size, and answers one response beat for
// every request beat. Allocate stores a region when it lies inside the
// configured memory size and overlaps no stored region of any owner; access
// is granted when the range lies inside one stored region of the same owner;
// free-owner drops that owner's regions and free-all empties the table.
// Requests are handled one at a time: allocate, access and free-owner walk
// the entry memory one entry per cycle through a single compare unit; an
// access hit or an allocation overlap ends the walk early, and an allocation
// that finds no free entry is refused as full. Free-all and out-of-bounds
// requests skip the walk. The request channel is ready whenever the
// sequencer is idle, even while a response beat still waits, and the memory
// size register may be written at any time the block is idle.
module process_memory_region_table
    import pmrt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_rsp        o_rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]               r_state,      n_state;
    logic [1:0]               r_cmd,        n_cmd;
    logic [7:0]               r_owner,      n_owner;
    logic signed [32:0]       r_first,      n_first;
    logic signed [33:0]       r_last,       n_last;
    logic [CNT_W-1:0]         r_issue,      n_issue;
    logic                     r_pend,       n_pend;
    logic [IDX_W-1:0]         r_pend_idx,   n_pend_idx;
    logic                     r_slot_found, n_slot_found;
    logic [IDX_W-1:0]         r_slot,       n_slot;
    logic [TABLE_ENTRIES-1:0] r_valid,      n_valid;
    logic [30:0]              r_mem_size,   n_mem_size;
    t_rsp                     r_result,     n_result;
    logic                     r_rsp_valid,  n_rsp_valid;
    t_rsp                     r_rsp,        n_rsp;

    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_wdata;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry           rd_entry;
    t_cmp_res         cmp_res;
    logic             req_acc;
    logic             in_bounds;
    logic             ent_valid;
    logic             owner_eq;

    assign req_acc     = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Entry storage: owner, base and last address of each region. Entry data is
    // used only when its valid bit is set, so the memory needs no clearing.
    pmrt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    // The one compare unit, shared by every entry of the walk.
    pmrt_cmp u_cmp (
        .i_first (r_first),
        .i_last  (r_last),
        .i_entry (rd_entry),
        .o_res   (cmp_res)
    );

    assign ram_raddr       = r_issue[IDX_W-1:0];
    assign ram_wdata.owner = r_owner;
    assign ram_wdata.base  = r_first[31:0];
    assign ram_wdata.last  = r_last[31:0];

    // A range is in bounds when its base is not negative and its last address
    // lies below the memory size.
    assign in_bounds = !r_first[32] && (r_last < $signed({3'b000, r_mem_size}));
    assign ent_valid = r_valid[r_pend_idx];
    assign owner_eq  = (rd_entry.owner == r_owner);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_owner      = r_owner;
        n_first      = r_first;
        n_last       = r_last;
        n_issue      = r_issue;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_slot_found = r_slot_found;
        n_slot       = r_slot;
        n_valid      = r_valid;
        n_mem_size   = r_mem_size;
        n_result     = r_result;
        n_rsp_valid  = r_rsp_valid;
        n_rsp        = r_rsp;
        ram_we       = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_mem_size = i_cfg_data;
        end

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    // The last address is base + size - 1, exact at 34 bits.
                    n_cmd   = i_req.command;
                    n_owner = i_req.owner_id;
                    n_first = $signed({i_req.range_base[31], i_req.range_base});
                    n_last  = $signed({{2{i_req.range_base[31]}}, i_req.range_base})
                            + $signed({3'b000, i_req.range_size}) - 34'sd1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_issue      = '0;
                n_pend       = 1'b0;
                n_slot_found = 1'b0;
                n_result.granted = 1'b1;
                n_result.status  = ST_OK;
                if (r_cmd == CMD_FREE_ALL) begin
                    n_valid = '0;
                    n_state = S_DONE;
                end else if (r_cmd == CMD_FREE_OWNER) begin
                    n_state = S_WALK;
                end else if (!in_bounds) begin
                    n_result.granted = 1'b0;
                    n_result.status  = ST_BOUNDS;
                    n_state = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // Issue one read a cycle; its data is examined in the following cycle.
                if (r_issue != CNT_END) begin
                    n_issue    = r_issue + 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_issue[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end

                if (r_pend) begin
                    case (r_cmd)
                        CMD_FREE_OWNER: begin
                            if (ent_valid && owner_eq) begin
                                n_valid[r_pend_idx] = 1'b0;
                            end
                        end
                        CMD_ACCESS: begin
                            if (ent_valid && owner_eq && cmp_res.contain) begin
                                n_result.granted = 1'b1;
                                n_result.status  = ST_OK;
                                n_pend  = 1'b0;
                                n_state = S_DONE;
                            end
                        end
                        CMD_ALLOCATE: begin
                            if (ent_valid && cmp_res.overlap) begin
                                n_result.granted = 1'b0;
                                n_result.status  = ST_CONFLICT;
                                n_pend  = 1'b0;
                                n_state = S_DONE;
                            end else if (!ent_valid && !r_slot_found) begin
                                n_slot_found = 1'b1;
                                n_slot       = r_pend_idx;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (r_issue == CNT_END) begin
                    // Every entry has been examined without an early exit.
                    n_state = S_DONE;
                    case (r_cmd)
                        CMD_ACCESS: begin
                            n_result.granted = 1'b0;
                            n_result.status  = ST_CONFLICT;
                        end
                        CMD_ALLOCATE: begin
                            if (r_slot_found) begin
                                ram_we           = 1'b1;
                                n_valid[r_slot]  = 1'b1;
                                n_result.granted = 1'b1;
                                n_result.status  = ST_OK;
                            end else begin
                                n_result.granted = 1'b0;
                                n_result.status  = ST_FULL;
                            end
                        end
                        default: begin
                            n_result.granted = 1'b1;
                            n_result.status  = ST_OK;
                        end
                    endcase
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid = 1'b1;
                    n_rsp       = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_valid     <= '0;
            r_mem_size  <= MEM_SIZE_RST;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_valid     <= n_valid;
            r_mem_size  <= n_mem_size;
            r_rsp_valid <= n_rsp_valid;
        end
        r_cmd        <= n_cmd;
        r_owner      <= n_owner;
        r_first      <= n_first;
        r_last       <= n_last;
        r_issue      <= n_issue;
        r_pend_idx   <= n_pend_idx;
        r_slot_found <= n_slot_found;
        r_slot       <= n_slot;
        r_result     <= n_result;
        r_rsp        <= n_rsp;
    end

`ifndef NO_ASSERTIONS
    // Only one request is in flight: after acceptance the channel closes.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !o_req_ready)
        else $error("request accepted while another is in flight");

    // Granted is set exactly when the status reports success.
    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.granted == (o_rsp.status == ST_OK)))
        else $error("granted disagrees with status");

    // At most one region is added per cycle.
    a_one_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_valid) <= $countones($past(r_valid)) + 1))
        else $error("more than one entry set in one cycle");

    // Free-all leaves the table empty.
    a_free_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) && (r_cmd == CMD_FREE_ALL) |=> (r_valid == '0))
        else $error("table not empty after free-all");
`endif

endmodule

### tb/sv/region_table_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, request and response channels of the region
// table, keeps its own copy of the table and flags every response beat that
// differs from the predicted verdict.
module region_table_checker
    import pmrt_pkg::*;
#(
    parameter int ENTRIES = TABLE_ENTRIES_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [30:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_req        i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_rsp        i_rsp,
    output int          o_fail_count,
    output int          o_outstanding
);

    logic [30:0] mem_size;
    logic        region_used  [ENTRIES];
    logic [7:0]  region_owner [ENTRIES];
    longint      region_lo    [ENTRIES];
    longint      region_hi    [ENTRIES];

    t_rsp pending_verdicts[$];
    int   failures;

    // Applies one request to the shadow table and returns the verdict.
    function automatic t_rsp predict_verdict(t_req r);
        longint first;
        longint last;
        int     slot;
        t_rsp   v;
        first = longint'($signed(r.range_base));
        last  = first + longint'(r.range_size) - 1;
        v.granted = 1'b1;
        v.status  = ST_OK;
        if (r.command == CMD_FREE_ALL) begin
            for (int i = 0; i < ENTRIES; i++) region_used[i] = 1'b0;
            return v;
        end
        if (r.command == CMD_FREE_OWNER) begin
            for (int i = 0; i < ENTRIES; i++)
                if (region_used[i] && region_owner[i] == r.owner_id) region_used[i] = 1'b0;
            return v;
        end
        v.granted = 1'b0;
        if (first < 0 || last >= longint'(mem_size)) begin
            v.status = ST_BOUNDS;
            return v;
        end
        if (r.command == CMD_ACCESS) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (region_used[i] && region_owner[i] == r.owner_id &&
                    first >= region_lo[i] && last <= region_hi[i]) begin
                    v.granted = 1'b1;
                    v.status  = ST_OK;
                    return v;
                end
            end
            v.status = ST_CONFLICT;
            return v;
        end
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (region_used[i]) begin
                if (!(last < region_lo[i] || first > region_hi[i])) begin
                    v.status = ST_CONFLICT;
                    return v;
                end
            end else if (slot < 0) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            v.status = ST_FULL;
            return v;
        end
        region_used[slot]  = 1'b1;
        region_owner[slot] = r.owner_id;
        region_lo[slot]    = first;
        region_hi[slot]    = last;
        v.granted = 1'b1;
        v.status  = ST_OK;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            mem_size = MEM_SIZE_RST;
            for (int i = 0; i < ENTRIES; i++) region_used[i] = 1'b0;
            pending_verdicts.delete();
        end else begin
            // Responses are matched before a request of the same edge is queued.
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_verdicts.size() == 0) begin
                    if (failures < 10)
                        $display("%0t: response beat granted=%0b status=%0d with none outstanding",
                                 $realtime, i_rsp.granted, i_rsp.status);
                    failures++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (i_rsp.granted !== want.granted || i_rsp.status !== want.status) begin
                        if (failures < 10)
                            $display("%0t: mismatch granted exp %0b got %0b, status exp %0d got %0d",
                                     $realtime, want.granted, i_rsp.granted,
                                     want.status, i_rsp.status);
                        failures++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) mem_size = i_cfg_data;
            if (i_req_valid && i_req_ready) pending_verdicts.push_back(predict_verdict(i_req));
        end
        o_outstanding <= pending_verdicts.size();
        o_fail_count  <= failures;
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

// Top of the region table bench. It only makes stimulus and gives the
// verdict; prediction and comparison live in the checker beside the block.
module tb;
    import pmrt_pkg::*;

    localparam int ENTRIES      = TABLE_ENTRIES_DFLT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 6;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [30:0] cfg_data   = '0;
    logic        req_valid  = 1'b0;
    logic        req_ready;
    t_req        req_beat   = '0;
    logic        rsp_valid;
    logic        rsp_ready  = 1'b0;
    t_rsp        rsp_beat;

    int fail_count;
    int outstanding;

    // When quiet is set neither side inserts idle cycles.
    bit quiet      = 1'b0;
    // The sender asks for a long receiver stall by bumping hold_asked.
    int hold_asked = 0;
    int hold_given = 0;

    // Stimulus bookkeeping only: the memory size in force, a pointer for
    // laying out non-overlapping allocations, and a few recently requested
    // regions that access checks aim at.
    longint     cur_msize   = 65536;
    longint     stride_next = 0;
    longint     seen_lo    [8];
    longint     seen_len   [8];
    logic [7:0] seen_owner [8];
    int         seen_n      = 0;
    int         watch_cycles;

    always #1 i_clk = ~i_clk;

    process_memory_region_table #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_beat),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_beat)
    );

    region_table_checker #(
        .ENTRIES(ENTRIES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req_beat),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp         (rsp_beat),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    function automatic t_req req_of(logic [1:0] c, logic [7:0] o, logic signed [31:0] b,
                                    logic [30:0] s);
        t_req r;
        r.command    = c;
        r.owner_id   = o;
        r.range_base = b;
        r.range_size = s;
        return r;
    endfunction

    // Picks a range that mostly sits in bounds for the current memory size:
    // anywhere, hugging the top end, in a small window near zero, or on the
    // running stride so that allocations succeed and the table fills.
    function automatic void place_range(output longint b, output longint len);
        longint m;
        m = cur_msize;
        case ($urandom_range(0, 9))
            0:       len = 0;
            7, 8:    len = $urandom_range(1, 32'(m / 8 + 1));
            9:       len = $urandom_range(0, 32'(m));
            default: len = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 4))
            0: b = $urandom_range(0, 32'(m - 1));
            1: b = m - len - $urandom_range(0, 2);
            2, 3: begin
                // The stride pointer keeps regions apart so allocations stick.
                len = $urandom_range(1, 32);
                b   = stride_next;
                stride_next = stride_next + len + $urandom_range(0, 3);
                if (stride_next >= m) stride_next = 0;
            end
            default: b = $urandom_range(0, (m - 1 < 1023) ? 32'(m - 1) : 1023);
        endcase
    endfunction

    function automatic t_req random_request();
        t_req   r;
        int     pick;
        int     k;
        longint b;
        longint len;
        longint off;
        r = '0;
        r.owner_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        pick = $urandom_range(0, 199);
        if (pick < 12) begin
            // Noise: every field takes any value, negative bases included.
            r.command    = 2'($urandom);
            r.owner_id   = 8'($urandom);
            r.range_base = $urandom;
            r.range_size = 31'($urandom);
        end else if (pick < 14) begin
            r.command    = CMD_FREE_ALL;
            r.range_base = $urandom;
            r.range_size = 31'($urandom);
        end else if (pick < 28) begin
            r.command    = CMD_FREE_OWNER;
            r.range_base = $urandom;
            r.range_size = 31'($urandom);
        end else if (pick < 100) begin
            r.command = CMD_ACCESS;
            if (seen_n > 0 && $urandom_range(0, 3) != 0) begin
                // Aim inside a region that was asked for, sometimes one past it.
                k   = $urandom_range(0, seen_n - 1);
                off = $urandom_range(0, 32'(seen_len[k]));
                len = $urandom_range(0, 32'(seen_len[k] - off));
                if ($urandom_range(0, 7) == 0) len = len + 1;
                b = seen_lo[k] + off;
                if ($urandom_range(0, 4) != 0) r.owner_id = seen_owner[k];
            end else begin
                place_range(b, len);
            end
            r.range_base = 32'(b);
            r.range_size = 31'(len);
        end else begin
            r.command = CMD_ALLOCATE;
            place_range(b, len);
            r.range_base = 32'(b);
            r.range_size = 31'(len);
            k = (seen_n < 8) ? seen_n : $urandom_range(0, 7);
            seen_lo[k]    = b;
            seen_len[k]   = len;
            seen_owner[k] = r.owner_id;
            if (seen_n < 8) seen_n++;
        end
        return r;
    endfunction

    // Offers one request beat after a random gap and returns at the edge
    // where it is accepted. With no gap, valid simply stays high.
    task automatic offer_request(input t_req beat);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_beat  <= beat;
        do @(posedge i_clk); while (!req_ready);
    endtask

    // Stops offering and waits until every predicted response has come back.
    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // The register is only written with the block idle.
    task automatic write_memory_size(input logic [30:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_msize   = longint'(value);
        stride_next = 0;
        seen_n      = 0;
    endtask

    // Response side: random stalls, plus one long hold-off when asked, which
    // backs the block up while the sender keeps offering beats.
    initial begin : response_sink
        int span;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_asked != hold_given) begin
                hold_given++;
                span = HOLD_CYCLES;
            end else begin
                span = quiet ? 0 : $urandom_range(0, 9);
            end
            if (span > 0) begin
                rsp_ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_valid);
        end
    end

    initial begin : watchdog
        for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++) @(posedge i_clk);
        $display("process_memory_region_table regression: fail");
        $finish;
    end

    initial begin : stimulus
        logic [30:0] size_plan [PHASES];
        int          item_plan [PHASES];

        // Memory sizes per phase: the smallest, the largest, a mid value,
        // a random one, the reset value and a small even one.
        size_plan = '{31'd1, 31'h7FFF_FFFF, 31'd4096, 31'd0, MEM_SIZE_RST, 31'd300};
        size_plan[3] = 31'($urandom_range(1, 32'h7FFF_FFFF));
        item_plan = '{40, 120, 120, 100, 120, 100};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset memory size of 65536.
        // The first access finds the table empty.
        offer_request(req_of(CMD_ACCESS, 8'd5, 32'sd0, 31'd1));
        offer_request(req_of(CMD_ALLOCATE, 8'd1, 32'sd0, 31'd16));
        // The new range touches the last address of the stored one.
        offer_request(req_of(CMD_ALLOCATE, 8'd2, 32'sd15, 31'd4));
        // Adjacent to the stored region, so no overlap.
        offer_request(req_of(CMD_ALLOCATE, 8'd2, 32'sd16, 31'd16));
        // Negative bases are out of bounds, the most negative one too.
        offer_request(req_of(CMD_ALLOCATE, 8'd7, -32'sd1, 31'd1));
        offer_request(req_of(CMD_ALLOCATE, 8'd7, 32'sh8000_0000, 31'd0));
        // The last address of memory is usable, one past it is not.
        offer_request(req_of(CMD_ALLOCATE, 8'd3, 32'sd65535, 31'd1));
        offer_request(req_of(CMD_ACCESS, 8'd3, 32'sd65535, 31'd2));
        // Largest base with largest size: exact arithmetic, no wrap.
        offer_request(req_of(CMD_ALLOCATE, 8'd255, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
        offer_request(req_of(CMD_ACCESS, 8'd1, 32'sd0, 31'd16));
        // A region of another owner does not cover an access.
        offer_request(req_of(CMD_ACCESS, 8'd2, 32'sd0, 31'd4));
        // An empty region ends one below its base; an empty access inside it passes.
        offer_request(req_of(CMD_ALLOCATE, 8'd4, 32'sd100, 31'd0));
        offer_request(req_of(CMD_ACCESS, 8'd4, 32'sd100, 31'd0));
        // Range fields of a free command are ignored.
        offer_request(req_of(CMD_FREE_OWNER, 8'd1, -32'sd1, 31'h7FFF_FFFF));
        offer_request(req_of(CMD_ACCESS, 8'd1, 32'sd0, 31'd1));
        // Fill the remaining entries, then one more allocation finds the table full.
        for (int i = 0; i < ENTRIES - 3; i++)
            offer_request(req_of(CMD_ALLOCATE, 8'(10 + i), 32'(200 + 8 * i), 31'd8));
        offer_request(req_of(CMD_ALLOCATE, 8'd0, 32'sd1000, 31'd1));
        offer_request(req_of(CMD_FREE_ALL, 8'd255, 32'sh8000_0000, 31'h7FFF_FFFF));

        // Random part, one phase per memory size.
        for (int p = 0; p < PHASES; p++) begin
            write_memory_size(size_plan[p]);
            quiet = (p == 3);
            if (p == 2) hold_asked++;
            for (int n = 0; n < item_plan[p]; n++) offer_request(random_request());
        end
        quiet = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("process_memory_region_table regression: pass");
        end else begin
            $display("process_memory_region_table regression: fail");
        end
        $finish;
    end

endmodule
